[rtl/core/sct_pkg.sv]
package sct_pkg;

	localparam int INDEX_W     = 5;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;
	localparam int SEARCH_W    = 7;
	localparam int MAX_RESULTS = 16;
	localparam int MAX_VALUES  = MAX_RESULTS - 1;
	localparam int VCOUNT_W    = 4;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_VT      = 8'h0B;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_QUERY   = 8'h3F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_COUNT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_COMMON_COUNT  = 2'd1;

	typedef enum logic [1:0] {
		CMD_FEED,
		CMD_TABLE,
		CMD_RESET
	} cmd_t;

	typedef enum logic [1:0] {
		CK_PLAIN,
		CK_BLANK,
		CK_TERM
	} char_kind_t;

	typedef enum logic [2:0] {
		PS_NEXT,
		PS_TERM,
		PS_NAME,
		PS_GAP,
		PS_VALUE,
		PS_ERROR
	} parse_state_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_SYNTAX,
		ST_NOT_FOUND
	} status_t;

	typedef enum logic [1:0] {
		CALL_NONE,
		CALL_QUERY,
		CALL_EVENT,
		CALL_SET
	} call_t;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_SEARCH,
		CS_EMIT
	} ctl_state_t;

	typedef struct packed {
		status_t status;
		call_t   kind;
	} parse_event_t;

	typedef struct packed {
		status_t              status;
		call_t                kind;
		logic [INDEX_W-1:0]   index;
		logic                 value_valid;
		logic [7:0]           value_char;
		logic                 last;
	} result_t;

	function automatic char_kind_t char_kind(input logic [7:0] c);
		char_kind_t k;
		unique case (c)
			CH_NUL, CH_LF, CH_CR, CH_SEMI: k = CK_TERM;
			CH_SPACE, CH_TAB, CH_VT, CH_FF: k = CK_BLANK;
			default: k = CK_PLAIN;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/scpi_command_tokenizer_top.sv]
// a feed character with no call, a table write or a parser reset is handled without a search;
// the result of such a feed is shown the cycle after the transfer
// a call searches the name table one row per cycle through its single read port,
// then emits its value characters (at most 15), each once the output register can take it
// the next item is taken once the last result sits in the output register and it can move
// reset: asynchronous, clears parse state, lengths, registers and control; memories keep contents
module scpi_command_tokenizer_top #(
	parameter int NAME_LENGTH = 8,
	parameter int VALUE_LENGTH = 16,
	parameter int TABLE_DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        command,
	input  logic [7:0]                        char_code,
	input  logic [4:0]                        table_entry,
	input  logic [2:0]                        table_position,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sct_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sct_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        status,
	output logic [1:0]                        call_kind,
	output logic [sct_pkg::INDEX_W-1:0]       command_index,
	output logic                              value_valid,
	output logic [7:0]                        value_char,
	output logic                              last
);

	import sct_pkg::*;

	localparam int ENTRY_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int POS_W   = $clog2(NAME_LENGTH);
	localparam int VLEN_W  = $clog2(VALUE_LENGTH);
	localparam int VIDX_W  = (VALUE_LENGTH > 2) ? $clog2(VALUE_LENGTH - 1) : 1;

	logic [CFG_DATA_W-1:0]        command_count_q, common_count_q;
	logic                         accept, feed, restart, tbl_wr_en;
	parse_event_t                 ev;
	logic [NAME_LENGTH-1:0][7:0]  name;
	logic [VLEN_W-1:0]            value_len;
	logic                         val_wr_en;
	logic [VIDX_W-1:0]            val_wr_addr;
	logic [7:0]                   val_wr_data;
	logic                         tbl_rd_en;
	logic [ENTRY_W-1:0]           tbl_rd_addr;
	logic [NAME_LENGTH-1:0][7:0]  tbl_rd_data;
	logic                         val_rd_en;
	logic [VIDX_W-1:0]            val_rd_addr;
	logic [0:0][7:0]              val_rd_data;
	result_t                      out_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_count_q <= '0;
			common_count_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_COMMAND_COUNT: command_count_q <= cfg_data;
				REG_COMMON_COUNT:  common_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		accept    = in_valid && !in_stall;
		feed      = accept && (command == CMD_FEED);
		restart   = accept && (command == CMD_RESET);
		// writes outside the table or the name are dropped
		tbl_wr_en = accept && (command == CMD_TABLE) &&
			(SEARCH_W'(table_entry) < SEARCH_W'(TABLE_DEPTH)) &&
			(5'(table_position) < 5'(NAME_LENGTH));
	end

	sct_parser #(
		.NAME_LENGTH  (NAME_LENGTH),
		.VALUE_LENGTH (VALUE_LENGTH)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.feed        (feed),
		.restart     (restart),
		.ch          (char_code),
		.ev          (ev),
		.name        (name),
		.value_len   (value_len),
		.val_wr_en   (val_wr_en),
		.val_wr_addr (val_wr_addr),
		.val_wr_data (val_wr_data)
	);

	sct_ram #(
		.LANES (NAME_LENGTH),
		.DEPTH (TABLE_DEPTH)
	) u_name_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (ENTRY_W'(table_entry)),
		.wr_lane (POS_W'(table_position)),
		.wr_data (char_code),
		.rd_en   (tbl_rd_en),
		.rd_addr (tbl_rd_addr),
		.rd_data (tbl_rd_data)
	);

	sct_ram #(
		.LANES (1),
		.DEPTH (VALUE_LENGTH - 1)
	) u_value_buf (
		.clk     (clk),
		.wr_en   (val_wr_en),
		.wr_addr (val_wr_addr),
		.wr_lane (1'b0),
		.wr_data (val_wr_data),
		.rd_en   (val_rd_en),
		.rd_addr (val_rd_addr),
		.rd_data (val_rd_data)
	);

	sct_dispatch #(
		.NAME_LENGTH  (NAME_LENGTH),
		.VALUE_LENGTH (VALUE_LENGTH),
		.TABLE_DEPTH  (TABLE_DEPTH)
	) u_dispatch (
		.clk           (clk),
		.arst_n        (arst_n),
		.feed          (feed),
		.ev            (ev),
		.name          (name),
		.value_len     (value_len),
		.command_count (command_count_q),
		.common_count  (common_count_q),
		.tbl_rd_en     (tbl_rd_en),
		.tbl_rd_addr   (tbl_rd_addr),
		.tbl_rd_data   (tbl_rd_data),
		.val_rd_en     (val_rd_en),
		.val_rd_addr   (val_rd_addr),
		.val_rd_data   (val_rd_data[0]),
		.in_stall      (in_stall),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_res       (out_res)
	);

	assign status        = out_res.status;
	assign call_kind     = out_res.kind;
	assign command_index = out_res.index;
	assign value_valid   = out_res.value_valid;
	assign value_char    = out_res.value_char;
	assign last          = out_res.last;

endmodule

[rtl/core/sct_ram.sv]
module sct_ram #(
	parameter int LANES = 1,
	parameter int DEPTH = 2,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1
) (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [ADDR_W-1:0]       wr_addr,
	input  logic [LANE_W-1:0]       wr_lane,
	input  logic [7:0]              wr_data,
	input  logic                    rd_en,
	input  logic [ADDR_W-1:0]       rd_addr,
	output logic [LANES-1:0][7:0]   rd_data
);

	logic [LANES-1:0][7:0] mem [DEPTH];
	logic [LANES-1:0][7:0] rd_data_q;

	// byte-lane write, one row read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr][wr_lane] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/sct_parser.sv]
module sct_parser #(
	parameter int NAME_LENGTH = 8,
	parameter int VALUE_LENGTH = 16,
	localparam int NLEN_W = $clog2(NAME_LENGTH + 1),
	localparam int NIDX_W = $clog2(NAME_LENGTH),
	localparam int VLEN_W = $clog2(VALUE_LENGTH),
	localparam int VIDX_W = (VALUE_LENGTH > 2) ? $clog2(VALUE_LENGTH - 1) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         feed,
	input  logic                         restart,
	input  logic [7:0]                   ch,
	output sct_pkg::parse_event_t        ev,
	output logic [NAME_LENGTH-1:0][7:0]  name,
	output logic [VLEN_W-1:0]            value_len,
	output logic                         val_wr_en,
	output logic [VIDX_W-1:0]            val_wr_addr,
	output logic [7:0]                   val_wr_data
);

	import sct_pkg::*;

	localparam int NAME_W = NAME_LENGTH * 8;

	parse_state_t              state_q, state_d;
	logic [NAME_LENGTH-1:0][7:0] name_q;
	logic [NLEN_W-1:0]         nlen_q, nlen_eff;
	logic [VLEN_W-1:0]         vlen_q, vlen_eff;
	char_kind_t                nat;
	call_t                     kind;
	logic                      in_name, in_gap, in_value;
	logic                      early_err, start_name, start_value;
	logic                      name_wr, val_wr;
	logic [7:0]                upper;

	always_comb begin
		nat         = char_kind(ch);
		state_d     = state_q;
		in_name     = 1'b0;
		in_gap      = 1'b0;
		in_value    = 1'b0;
		early_err   = 1'b0;
		start_name  = 1'b0;
		start_value = 1'b0;
		name_wr     = 1'b0;
		val_wr      = 1'b0;
		kind        = CALL_NONE;
		upper       = ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_Z)) ? (ch ^ CASE_BIT) : ch;

		unique case (state_q)
			PS_TERM: begin
				if (nat == CK_PLAIN) begin
					state_d   = PS_ERROR;
					early_err = 1'b1;
				end else if (nat == CK_TERM) begin
					state_d = PS_NEXT;
				end
			end
			PS_NEXT: begin
				if ((ch != CH_COLON) && (nat == CK_PLAIN)) begin
					state_d    = PS_NAME;
					start_name = 1'b1;
					in_name    = 1'b1;
				end
			end
			PS_NAME:  in_name = 1'b1;
			PS_GAP:   in_gap = 1'b1;
			PS_VALUE: in_value = 1'b1;
			default: begin
				state_d   = PS_ERROR;
				early_err = 1'b1;
			end
		endcase

		nlen_eff = start_name ? '0 : nlen_q;

		if (in_name) begin
			priority if (ch == CH_QUERY) begin
				kind = CALL_QUERY;
			end else if (ch == CH_COLON) begin
				state_d = PS_NEXT;
			end else if (nat != CK_PLAIN) begin
				state_d = PS_GAP;
				in_gap  = 1'b1;
			end else begin
				// characters past the name length are dropped
				name_wr = (nlen_eff < NLEN_W'(NAME_LENGTH));
			end
		end

		if (in_gap) begin
			if (nat == CK_TERM) begin
				kind = CALL_EVENT;
			end else if (nat == CK_PLAIN) begin
				state_d     = PS_VALUE;
				start_value = 1'b1;
				in_value    = 1'b1;
			end
		end

		vlen_eff = start_value ? '0 : vlen_q;

		if (in_value) begin
			if (nat != CK_PLAIN) begin
				kind = CALL_SET;
			end else begin
				val_wr = (vlen_eff < VLEN_W'(VALUE_LENGTH - 1));
			end
		end

		ev.kind   = CALL_NONE;
		ev.status = early_err ? ST_SYNTAX : ST_OK;
		if (kind != CALL_NONE) begin
			if (nlen_eff == '0) begin
				state_d   = PS_ERROR;
				ev.status = ST_SYNTAX;
			end else begin
				state_d = (nat == CK_TERM) ? PS_NEXT : PS_TERM;
				ev.kind = kind;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_NEXT;
			nlen_q  <= '0;
			vlen_q  <= '0;
		end else if (restart) begin
			state_q <= PS_NEXT;
		end else if (feed) begin
			state_q <= state_d;
			nlen_q  <= nlen_eff + NLEN_W'(name_wr);
			vlen_q  <= vlen_eff + VLEN_W'(val_wr);
		end
	end

	// a new name starts cleared, with its first character in lane zero
	always_ff @(posedge clk) begin
		if (feed) begin
			if (start_name) begin
				name_q <= name_wr ? NAME_W'(upper) : '0;
			end else if (name_wr) begin
				name_q[nlen_eff[NIDX_W-1:0]] <= upper;
			end
		end
	end

	assign name        = name_q;
	assign value_len   = vlen_q;
	assign val_wr_en   = feed && val_wr;
	assign val_wr_addr = vlen_eff[VIDX_W-1:0];
	assign val_wr_data = ch;

endmodule

[rtl/core/sct_dispatch.sv]
module sct_dispatch #(
	parameter int NAME_LENGTH = 8,
	parameter int VALUE_LENGTH = 16,
	parameter int TABLE_DEPTH = 32,
	localparam int ENTRY_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
	localparam int VLEN_W = $clog2(VALUE_LENGTH),
	localparam int VIDX_W = (VALUE_LENGTH > 2) ? $clog2(VALUE_LENGTH - 1) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              feed,
	input  sct_pkg::parse_event_t             ev,
	input  logic [NAME_LENGTH-1:0][7:0]       name,
	input  logic [VLEN_W-1:0]                 value_len,
	input  logic [sct_pkg::CFG_DATA_W-1:0]    command_count,
	input  logic [sct_pkg::CFG_DATA_W-1:0]    common_count,
	output logic                              tbl_rd_en,
	output logic [ENTRY_W-1:0]                tbl_rd_addr,
	input  logic [NAME_LENGTH-1:0][7:0]       tbl_rd_data,
	output logic                              val_rd_en,
	output logic [VIDX_W-1:0]                 val_rd_addr,
	input  logic [7:0]                        val_rd_data,
	output logic                              in_stall,
	output logic                              out_valid,
	input  logic                              out_stall,
	output sct_pkg::result_t                  out_res
);

	import sct_pkg::*;

	ctl_state_t               state_q, state_d;
	logic                     out_valid_q;
	result_t                  res_q, res_d;
	logic                     load;
	logic                     out_free;
	logic [SEARCH_W-1:0]      cnt_q, cnt_d, limit;
	logic                     issue, match;
	logic                     pend_s1, pend_d;
	logic [ENTRY_W-1:0]       idx_s1, idx_d;
	logic [INDEX_W-1:0]       idx_q, idxq_d;
	call_t                    kind_q, kind_d;
	logic [VCOUNT_W-1:0]      n_q, n_d, k_q, k_d, nval;
	logic [4:0]               vl_wide;

	always_comb begin
		out_free = !out_valid_q || !out_stall;
		in_stall = !((state_q == CS_IDLE) && out_free);
		limit    = (SEARCH_W'(command_count) > SEARCH_W'(TABLE_DEPTH)) ?
			SEARCH_W'(TABLE_DEPTH) : SEARCH_W'(command_count);
		issue    = cnt_q < limit;
		match    = pend_s1 && (tbl_rd_data == name);
		vl_wide  = 5'(value_len);
		if (kind_q != CALL_SET) begin
			nval = '0;
		end else if (vl_wide > 5'(MAX_VALUES)) begin
			nval = VCOUNT_W'(MAX_VALUES);
		end else begin
			nval = vl_wide[VCOUNT_W-1:0];
		end

		state_d     = state_q;
		load        = 1'b0;
		res_d       = '0;
		cnt_d       = cnt_q;
		pend_d      = 1'b0;
		idx_d       = idx_s1;
		idxq_d      = idx_q;
		kind_d      = kind_q;
		n_d         = n_q;
		k_d         = k_q;
		tbl_rd_en   = 1'b0;
		tbl_rd_addr = cnt_q[ENTRY_W-1:0];
		val_rd_en   = 1'b0;
		val_rd_addr = '0;

		unique case (state_q)
			CS_IDLE: begin
				if (feed) begin
					if (ev.kind == CALL_NONE) begin
						load         = 1'b1;
						res_d.status = ev.status;
						res_d.last   = 1'b1;
					end else begin
						state_d = CS_SEARCH;
						kind_d  = ev.kind;
						// common commands live at the bottom of the table
						cnt_d   = (name[0] == CH_STAR) ? '0 : SEARCH_W'(common_count);
					end
				end
			end
			CS_SEARCH: begin
				if (match) begin
					load        = 1'b1;
					res_d.kind  = kind_q;
					res_d.index = INDEX_W'(idx_s1);
					res_d.last  = (nval == '0);
					idxq_d      = INDEX_W'(idx_s1);
					n_d         = nval;
					k_d         = '0;
					if (nval == '0) begin
						state_d = CS_IDLE;
					end else begin
						state_d   = CS_EMIT;
						val_rd_en = 1'b1;
					end
				end else if (!pend_s1 && !issue) begin
					load         = 1'b1;
					res_d.status = ST_NOT_FOUND;
					res_d.last   = 1'b1;
					state_d      = CS_IDLE;
				end else if (issue) begin
					// one row per cycle, compared once its registered read data returns
					tbl_rd_en = 1'b1;
					cnt_d     = cnt_q + SEARCH_W'(1);
					pend_d    = 1'b1;
					idx_d     = cnt_q[ENTRY_W-1:0];
				end
			end
			CS_EMIT: begin
				if (out_free) begin
					load              = 1'b1;
					res_d.kind        = kind_q;
					res_d.index       = idx_q;
					res_d.value_valid = 1'b1;
					res_d.value_char  = val_rd_data;
					res_d.last        = (k_q == (n_q - VCOUNT_W'(1)));
					k_d               = k_q + VCOUNT_W'(1);
					if (res_d.last) begin
						state_d = CS_IDLE;
					end else begin
						// prefetch the next character
						val_rd_en   = 1'b1;
						val_rd_addr = VIDX_W'(k_q + VCOUNT_W'(1));
					end
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_s1 <= pend_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_q  <= cnt_d;
		idx_s1 <= idx_d;
		idx_q  <= idxq_d;
		kind_q <= kind_d;
		n_q    <= n_d;
		k_q    <= k_d;
		if (load) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != CS_IDLE) |-> in_stall)
		else $error("input taken while a command is being dispatched");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (state_q != CS_IDLE)) |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten before transfer");

	a_compare_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> ($past(state_q) == CS_SEARCH))
		else $error("table compare outside of a search");

	a_value_is_set: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.value_valid) |-> (res_q.kind == CALL_SET))
		else $error("value character on a call that is not a set");

	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_EMIT) |-> (k_q < n_q))
		else $error("value emission ran past its count");

endmodule

[verif/scpi_command_tokenizer_checker.sv]
module scpi_command_tokenizer_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [1:0]                      command,
	input  logic [7:0]                      char_code,
	input  logic [4:0]                      table_entry,
	input  logic [2:0]                      table_position,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [sct_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sct_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic [1:0]                      status,
	input  logic [1:0]                      call_kind,
	input  logic [sct_pkg::INDEX_W-1:0]     command_index,
	input  logic                            value_valid,
	input  logic [7:0]                      value_char,
	input  logic                            last,
	output int                              fail_count,
	output int                              pending,
	output int                              n_results,
	output int                              n_found,
	output int                              n_not_found,
	output int                              n_syntax
);
	timeunit 1ns;
	timeprecision 1ps;

	import sct_pkg::*;

	localparam int NAME_LEN   = 8;
	localparam int VALUE_KEEP = 15;
	localparam int ENTRIES    = 32;

	parse_state_t pstate;
	logic [7:0]   name_buf [NAME_LEN];
	int           name_len;
	logic [7:0]   value_buf [VALUE_KEEP];
	int           value_len;
	logic [7:0]   names [ENTRIES][NAME_LEN];
	logic [5:0]   cmd_count;
	logic [5:0]   common_count;
	result_t      dispatch_due [$];

	function automatic char_kind_t classify(logic [7:0] c);
		if (c == CH_NUL || c == CH_LF || c == CH_CR || c == CH_SEMI)
			return CK_TERM;
		if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)
			return CK_BLANK;
		return CK_PLAIN;
	endfunction

	function automatic void expect_result(status_t s, call_t k, logic [4:0] idx, logic vv,
			logic [7:0] vc, logic lst);
		result_t r;
		r.status      = s;
		r.kind        = k;
		r.index       = idx;
		r.value_valid = vv;
		r.value_char  = vc;
		r.last        = lst;
		dispatch_due.push_back(r);
	endfunction

	function automatic void syntax_fault();
		pstate = PS_ERROR;
		n_syntax++;
		expect_result(ST_SYNTAX, CALL_NONE, '0, 1'b0, '0, 1'b1);
	endfunction

	// first matching row wins; '*' names scan the common rows too
	function automatic int find_entry();
		int lim;
		int first;
		bit same;
		lim   = (cmd_count > ENTRIES) ? ENTRIES : int'(cmd_count);
		first = (name_buf[0] == CH_STAR) ? 0 : int'(common_count);
		for (int i = first; i < lim; i++) begin
			same = 1'b1;
			for (int j = 0; j < NAME_LEN; j++)
				if (names[i][j] != name_buf[j])
					same = 1'b0;
			if (same)
				return i;
		end
		return -1;
	endfunction

	function automatic void parse_item(logic [1:0] cmd, logic [7:0] c, logic [4:0] e,
			logic [2:0] p);
		char_kind_t ck;
		call_t      call;
		bit         in_name;
		bit         in_gap;
		bit         in_value;
		int         hit;
		int         n;
		call     = CALL_NONE;
		in_name  = 1'b0;
		in_gap   = 1'b0;
		in_value = 1'b0;
		if (cmd == CMD_TABLE) begin
			names[e][p] = c;
			return;
		end
		if (cmd == CMD_RESET) begin
			pstate = PS_NEXT;
			return;
		end
		if (cmd != CMD_FEED)
			return;
		ck = classify(c);
		case (pstate)
			PS_TERM: begin
				if (ck == CK_PLAIN) begin
					syntax_fault();
					return;
				end
				if (ck == CK_TERM)
					pstate = PS_NEXT;
			end
			PS_NEXT: begin
				if (c != CH_COLON && ck == CK_PLAIN) begin
					pstate   = PS_NAME;
					name_len = 0;
					for (int i = 0; i < NAME_LEN; i++)
						name_buf[i] = '0;
					in_name = 1'b1;
				end
			end
			PS_NAME: in_name = 1'b1;
			PS_GAP: in_gap = 1'b1;
			PS_VALUE: in_value = 1'b1;
			default: begin
				syntax_fault();
				return;
			end
		endcase

		if (in_name) begin
			if (c == CH_QUERY) begin
				call = CALL_QUERY;
			end else if (c == CH_COLON) begin
				pstate = PS_NEXT;
			end else if (ck != CK_PLAIN) begin
				pstate = PS_GAP;
				in_gap = 1'b1;
			end else if (name_len < NAME_LEN) begin
				name_buf[name_len] = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c ^ CASE_BIT : c;
				name_len++;
			end
		end
		if (in_gap) begin
			if (ck == CK_TERM) begin
				call = CALL_EVENT;
			end else if (ck == CK_PLAIN) begin
				pstate    = PS_VALUE;
				value_len = 0;
				for (int i = 0; i < VALUE_KEEP; i++)
					value_buf[i] = '0;
				in_value = 1'b1;
			end
		end
		if (in_value) begin
			if (ck != CK_PLAIN) begin
				call = CALL_SET;
			end else if (value_len < VALUE_KEEP) begin
				value_buf[value_len] = c;
				value_len++;
			end
		end

		if (call == CALL_NONE) begin
			expect_result(ST_OK, CALL_NONE, '0, 1'b0, '0, 1'b1);
			return;
		end
		if (name_len == 0) begin
			syntax_fault();
			return;
		end
		pstate = (ck == CK_TERM) ? PS_NEXT : PS_TERM;
		hit = find_entry();
		if (hit < 0) begin
			n_not_found++;
			expect_result(ST_NOT_FOUND, CALL_NONE, '0, 1'b0, '0, 1'b1);
			return;
		end
		n_found++;
		n = (call == CALL_SET) ? value_len : 0;
		if (n > MAX_VALUES)
			n = MAX_VALUES;
		expect_result(ST_OK, call, 5'(hit), 1'b0, '0, n == 0);
		for (int k = 0; k < n; k++)
			expect_result(ST_OK, call, 5'(hit), 1'b1, value_buf[k], k == n - 1);
	endfunction

	function automatic void report(string what, result_t want, result_t got);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t %s: want st %0d kind %0d idx %0d vv %0d ch %02h last %0d, %s",
				$time, what, want.status, want.kind, want.index, want.value_valid,
				want.value_char, want.last,
				$sformatf("got st %0d kind %0d idx %0d vv %0d ch %02h last %0d",
				got.status, got.kind, got.index, got.value_valid, got.value_char,
				got.last));
	endfunction

	// result side first: a transfer that lands with a new input belongs to an older one
	always @(posedge clk or negedge arst_n) begin
		result_t got;
		if (!arst_n) begin
			pstate       = PS_NEXT;
			name_len     = 0;
			value_len    = 0;
			cmd_count    = '0;
			common_count = '0;
			for (int i = 0; i < NAME_LEN; i++)
				name_buf[i] = '0;
			for (int i = 0; i < VALUE_KEEP; i++)
				value_buf[i] = '0;
			for (int i = 0; i < ENTRIES; i++)
				for (int j = 0; j < NAME_LEN; j++)
					names[i][j] = '0;
			dispatch_due.delete();
			fail_count  = 0;
			pending     = 0;
			n_results   = 0;
			n_found     = 0;
			n_not_found = 0;
			n_syntax    = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_COMMAND_COUNT)
					cmd_count = cfg_data;
				else if (cfg_index == REG_COMMON_COUNT)
					common_count = cfg_data;
			end
			if (out_valid && !out_stall) begin
				got = {status, call_kind, command_index, value_valid, value_char, last};
				n_results++;
				if (dispatch_due.size() == 0)
					report("result transfer with nothing expected", '0, got);
				else if (got !== dispatch_due[0])
					report("result mismatch", dispatch_due.pop_front(), got);
				else
					void'(dispatch_due.pop_front());
			end
			if (in_valid && !in_stall)
				parse_item(command, char_code, table_entry, table_position);
			pending = dispatch_due.size();
		end
	end

endmodule

[verif/scpi_command_tokenizer_top_test.sv]
module scpi_command_tokenizer_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sct_pkg::*;

	localparam logic [1:0]             CMD_SPARE = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [1:0]             command;
	logic [7:0]             char_code;
	logic [4:0]             table_entry;
	logic [2:0]             table_position;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [1:0]             status;
	logic [1:0]             call_kind;
	logic [INDEX_W-1:0]     command_index;
	logic                   value_valid;
	logic [7:0]             value_char;
	logic                   last;

	int fail_count;
	int pending;
	int n_results;
	int n_found;
	int n_not_found;
	int n_syntax;

	bit         idle_on = 1'b1;
	int         sent_items = 0;
	int         n_settings = 0;
	int         quiet_cycles;
	logic [7:0] line_buf [$];
	string      loaded [32];
	string      stock_names [32] = '{
		"*IDN", "*RST", "*CLS", "*ESE", "*ESR", "*OPC", "*SRE", "*STB",
		"VOLT", "CURR", "FREQUENC", "MEAS", "OUTP", "INP", "SOUR", "SENS",
		"TRIG", "SYST", "CH1", "DAT2", "A", "Z9", "RANGE", "*TST",
		"POW", "LIMIT", "{}[]~!", "ABORT", "INIT", "MODE", "VOLT", "*WAI"
	};
	logic [5:0] totals [6]  = '{6'd32, 6'd63, 6'd0, 6'd12, 6'd63, 6'd20};
	logic [5:0] commons [6] = '{6'd8, 6'd16, 6'd0, 6'd63, 6'd0, 6'd5};

	scpi_command_tokenizer_top dut (.*);
	scpi_command_tokenizer_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk)
		out_stall <= idle_on && ($urandom_range(0, 99) < 19);

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (cfg_valid && cfg_ready) ||
					(out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("no transfer for %0d cycles, %0d results outstanding", quiet_cycles, pending);
		$display("scpi_command_tokenizer_top: mismatch");
		$finish;
	end

	task automatic push_item(logic [1:0] cmd, logic [7:0] ch, logic [4:0] e, logic [2:0] p);
		while (idle_on && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		char_code      <= ch;
		table_entry    <= e;
		table_position <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		sent_items++;
	endtask

	// entry and position are don't-care outside table writes
	task automatic poke(logic [1:0] cmd, logic [7:0] ch);
		push_item(cmd, ch, 5'($urandom), 3'($urandom));
	endtask

	task automatic load_entry(int e, string nm);
		for (int p = 0; p < 8; p++)
			push_item(CMD_TABLE, (p < nm.len()) ? nm[p] : CH_NUL, 5'(e), 3'(p));
		loaded[e] = nm;
	endtask

	task automatic append(string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic flush_line();
		foreach (line_buf[i])
			poke(CMD_FEED, line_buf[i]);
		line_buf.delete();
	endtask

	// sender holds off until every predicted result has been taken
	task automatic settle();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_config(logic [5:0] total, logic [5:0] common);
		settle();
		write_reg(REG_SPARE, ~common);
		write_reg(REG_COMMAND_COUNT, total);
		write_reg(REG_COMMON_COUNT, common);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [7:0] mixed_case(logic [7:0] b);
		if (b >= "A" && b <= "Z" && $urandom_range(0, 1))
			return b | CASE_BIT;
		return b;
	endfunction

	function automatic logic [7:0] pick_term();
		case ($urandom_range(0, 3))
			0: return CH_NUL;
			1: return CH_LF;
			2: return CH_CR;
			default: return CH_SEMI;
		endcase
	endfunction

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_VT;
			default: return CH_FF;
		endcase
	endfunction

	task automatic gen_command();
		string      nm;
		logic [7:0] b;
		int         n;
		if ($urandom_range(0, 99) < 15)
			poke(CMD_RESET, 8'($urandom));
		if ($urandom_range(0, 99) < 15)
			line_buf.push_back(pick_blank());
		if ($urandom_range(0, 99) < 20)
			line_buf.push_back(CH_COLON);
		// header segment that the colon throws away
		if ($urandom_range(0, 99) < 20) begin
			append(loaded[$urandom_range(8, 31)]);
			line_buf.push_back(CH_COLON);
		end
		if ($urandom_range(0, 99) < 10) begin
			repeat ($urandom_range(1, 10))
				line_buf.push_back(mixed_case(8'($urandom_range(65, 90))));
		end else begin
			nm = loaded[$urandom_range(0, 31)];
			for (int i = 0; i < nm.len(); i++)
				line_buf.push_back(mixed_case(nm[i]));
			if (nm.len() == 8 && $urandom_range(0, 1))
				repeat ($urandom_range(1, 3))
					line_buf.push_back(mixed_case(8'($urandom_range(65, 90))));
		end
		case ($urandom_range(0, 2))
			0: begin
				line_buf.push_back(CH_QUERY);
				if ($urandom_range(0, 99) < 30)
					line_buf.push_back(pick_blank());
				line_buf.push_back(pick_term());
			end
			1: begin
				if ($urandom_range(0, 99) < 40)
					line_buf.push_back(pick_blank());
				line_buf.push_back(pick_term());
			end
			default: begin
				repeat ($urandom_range(1, 2))
					line_buf.push_back(pick_blank());
				n = ($urandom_range(0, 99) < 20) ? $urandom_range(14, 20) : $urandom_range(1, 6);
				repeat (n) begin
					b = 8'($urandom_range(33, 255));
					line_buf.push_back((b == CH_SEMI) ? CH_QUERY : b);
				end
				if ($urandom_range(0, 99) < 30)
					line_buf.push_back(pick_blank());
				line_buf.push_back(pick_term());
			end
		endcase
		flush_line();
	endtask

	task automatic gen_noise();
		if ($urandom_range(0, 1)) begin
			append(loaded[$urandom_range(0, 31)]);
			line_buf.push_back(CH_QUERY);
		end
		repeat ($urandom_range(1, 6))
			line_buf.push_back(8'($urandom));
		flush_line();
		if ($urandom_range(0, 99) < 70)
			poke(CMD_RESET, 8'($urandom));
	endtask

	initial begin
		int mark;
		int pick;
		in_valid       = 1'b0;
		command        = CMD_FEED;
		char_code      = '0;
		table_entry    = '0;
		table_position = '0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		arst_n         = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int e = 0; e < 32; e++)
			load_entry(e, stock_names[e]);
		set_config(6'd32, 6'd8);

		append("?");
		flush_line();
		poke(CMD_FEED, "z");
		poke(CMD_RESET, 8'hFF);
		poke(CMD_SPARE, 8'h00);
		append("*idn?\n");
		append("b:ch1;");
		append("z9 ");
		line_buf.push_back(8'hFF);
		append("x;no;a?x");
		flush_line();
		poke(CMD_RESET, 8'h00);

		// first setting runs without idling on either side
		for (int ph = 0; ph < 6; ph++) begin
			set_config(totals[ph], commons[ph]);
			idle_on = (ph != 0);
			mark = sent_items;
			while (sent_items - mark < ((ph == 0) ? 60 : 16)) begin
				pick = $urandom_range(0, 99);
				if (pick < 68)
					gen_command();
				else if (pick < 76)
					load_entry($urandom_range(0, 31), stock_names[$urandom_range(0, 31)]);
				else if (pick < 88)
					gen_noise();
				else if (pick < 94)
					poke(CMD_RESET, 8'($urandom));
				else if (pick < 97)
					poke(CMD_SPARE, 8'($urandom));
				else
					settle();
			end
		end

		settle();
		repeat (40) @(negedge clk);
		$display("%0d items sent over %0d register settings, %0d results compared",
			sent_items, n_settings, n_results);
		$display("%0d commands dispatched, %0d unknown names, %0d syntax errors",
			n_found, n_not_found, n_syntax);
		if (fail_count == 0 && pending == 0) begin
			$display("scpi_command_tokenizer_top: match");
		end else begin
			$display("%0d failures, %0d results never arrived", fail_count, pending);
			$display("scpi_command_tokenizer_top: mismatch");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/sct_pkg.sv
rtl/core/sct_ram.sv
rtl/core/sct_parser.sv
rtl/core/sct_dispatch.sv
rtl/core/scpi_command_tokenizer_top.sv
verif/scpi_command_tokenizer_checker.sv
verif/scpi_command_tokenizer_top_test.sv
